// File: sv/accumulator_alu_with_flags_top_macros.svh
// assertion macros for the accumulator alu checker
`ifndef ACCUMULATOR_ALU_WITH_FLAGS_TOP_MACROS_SVH
`define ACCUMULATOR_ALU_WITH_FLAGS_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define AALU_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("accumulator alu check failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define AALU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("accumulator alu check failed");

`endif

// File: sv/aalu_pkg.sv
// types, operation codes and helpers shared by the accumulator alu files
package aalu_pkg;

  localparam logic [4:0] FUNC_ADD       = 5'd0;
  localparam logic [4:0] FUNC_ADC       = 5'd1;
  localparam logic [4:0] FUNC_SUB       = 5'd2;
  localparam logic [4:0] FUNC_SBB       = 5'd3;
  localparam logic [4:0] FUNC_ANA       = 5'd4;
  localparam logic [4:0] FUNC_XRA       = 5'd5;
  localparam logic [4:0] FUNC_ORA       = 5'd6;
  localparam logic [4:0] FUNC_CMP       = 5'd7;
  localparam logic [4:0] FUNC_RLC       = 5'd8;
  localparam logic [4:0] FUNC_RRC       = 5'd9;
  localparam logic [4:0] FUNC_RAL       = 5'd10;
  localparam logic [4:0] FUNC_RAR       = 5'd11;
  localparam logic [4:0] FUNC_CMA       = 5'd12;
  localparam logic [4:0] FUNC_CMC       = 5'd13;
  localparam logic [4:0] FUNC_DAA       = 5'd14;
  localparam logic [4:0] FUNC_INR       = 5'd15;
  localparam logic [4:0] FUNC_DCR       = 5'd16;
  localparam logic [4:0] FUNC_LOAD_ACC  = 5'd17;
  localparam logic [4:0] FUNC_LOAD_FLAG = 5'd18;

  localparam logic [7:0] DAA_LO_ADJ = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ = 8'h60;
  localparam logic [3:0] BCD_MAX    = 4'h9;
  localparam logic [7:0] MINUS_ONE  = 8'hff;

  typedef struct packed {
    logic [4:0] func;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [7:0] acc_out;
    logic [7:0] value_out;
    logic [7:0] status_out;
  } out_item_t;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } flags_t;

  typedef struct packed {
    logic [7:0] acc;
    flags_t     flags;
  } alu_state_t;

  // even parity: one when the number of set bits is even
  function automatic logic even_parity(input logic [7:0] v);
    even_parity = ~(^v);
  endfunction

  // sign, zero and parity from a byte, with the given ac and cy
  function automatic flags_t szp_flags(input logic [7:0] v, input logic ac,
                                       input logic cy);
    flags_t f;
    f.s  = v[7];
    f.z  = (v == 8'd0);
    f.p  = even_parity(v);
    f.ac = ac;
    f.cy = cy;
    szp_flags = f;
  endfunction

  // status byte: s z 0 ac 0 p 1 cy
  function automatic logic [7:0] pack_status(input flags_t f);
    pack_status = {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.cy};
  endfunction

endpackage

// File: sv/accumulator_alu_with_flags_top.sv
// top level of the 8080-style accumulator alu with flags
//
// usage
// - input channel: in_valid_i / in_stall_o carry an operation code and an
//   operand byte; a transfer happens on a rising edge with valid high and
//   stall low
// - output channel: out_valid_o / out_stall_i carry the new accumulator,
//   the inr/dcr register value and the packed status byte, one result per
//   input transfer and in the same order
// - path: an accepted item sits in the input register, then passes through
//   the alu into the result register once that register is free
// - throughput: one item per cycle while the receiver does not stall; the
//   accumulator and flag feedback through the alu is combinational, so items follow back to back
// - stalling: while the receiver stalls a full result register, the item in
//   the input register waits there and in_stall_o rises only if that
//   register is occupied; the result payload holds steady
// - reset: accumulator and all flags clear, both stages empty
module accumulator_alu_with_flags_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  aalu_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output aalu_pkg::out_item_t out_data_o
);

  // input register stage
  logic               in_valid_q;
  logic               in_valid_d;
  aalu_pkg::in_item_t in_q;

  // result register stage
  logic                out_valid_q;
  logic                out_valid_d;
  aalu_pkg::out_item_t out_q;
  aalu_pkg::out_item_t out_d;

  // architectural state
  aalu_pkg::alu_state_t state_q;
  aalu_pkg::alu_state_t state_d;
  logic [7:0]           value;

  logic out_free;
  logic in_take;
  logic advance;

  // result slot can take a new item when empty or being drained now
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_take || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  aalu_core u_core (
    .func_i    (in_q.func),
    .operand_i (in_q.operand),
    .state_i   (state_q),
    .state_o   (state_d),
    .value_o   (value)
  );

  assign out_d.acc_out    = state_d.acc;
  assign out_d.value_out  = value;
  assign out_d.status_out = aalu_pkg::pack_status(state_d.flags);

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      // state moves only when an item passes through the alu
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: sv/aalu_core.sv
// combinational alu: next accumulator, next flags and register value
module aalu_core (
  input  logic [4:0]          func_i,
  input  logic [7:0]          operand_i,
  input  aalu_pkg::alu_state_t state_i,
  output aalu_pkg::alu_state_t state_o,
  output logic [7:0]          value_o
);

  logic [7:0]     a;
  logic           cy;
  logic           sub_op;
  logic [7:0]     b_sel;
  logic           cin;
  logic [8:0]     sum9;
  logic [4:0]     half5;
  logic [7:0]     incdec;
  logic           lo_adj;
  logic [4:0]     daa_lo5;
  logic [7:0]     daa_a1;
  logic           hi_adj;
  logic [7:0]     daa_a2;
  aalu_pkg::flags_t arith_flags;

  assign a      = state_i.acc;
  assign cy     = state_i.flags.cy;
  assign sub_op = func_i inside {aalu_pkg::FUNC_SUB, aalu_pkg::FUNC_SBB, aalu_pkg::FUNC_CMP};
  assign b_sel  = sub_op ? ~operand_i : operand_i;

  always_comb begin
    case (func_i)
      aalu_pkg::FUNC_ADC:                    cin = cy;
      aalu_pkg::FUNC_SUB, aalu_pkg::FUNC_CMP: cin = 1'b1;
      aalu_pkg::FUNC_SBB:                    cin = ~cy;
      default:                               cin = 1'b0;
    endcase
  end

  assign sum9  = {1'b0, a} + {1'b0, b_sel} + {8'd0, cin};
  assign half5 = {1'b0, a[3:0]} + {1'b0, b_sel[3:0]} + {4'd0, cin};
  // subtract group reports borrow as the inverted carry
  assign arith_flags = aalu_pkg::szp_flags(sum9[7:0], half5[4], sub_op ? ~sum9[8] : sum9[8]);

  assign incdec = (func_i == aalu_pkg::FUNC_INR) ? (operand_i + 8'd1)
                                                 : (operand_i + aalu_pkg::MINUS_ONE);

  // decimal adjust, low then high nibble
  assign lo_adj  = (a[3:0] > aalu_pkg::BCD_MAX) || state_i.flags.ac;
  assign daa_lo5 = {1'b0, a[3:0]} + {1'b0, aalu_pkg::DAA_LO_ADJ[3:0]};
  assign daa_a1  = lo_adj ? (a + aalu_pkg::DAA_LO_ADJ) : a;
  assign hi_adj  = (daa_a1[7:4] > aalu_pkg::BCD_MAX) || cy;
  assign daa_a2  = hi_adj ? (daa_a1 + aalu_pkg::DAA_HI_ADJ) : daa_a1;

  always_comb begin
    state_o = state_i;
    value_o = 8'd0;
    case (func_i)
      aalu_pkg::FUNC_ADD, aalu_pkg::FUNC_ADC, aalu_pkg::FUNC_SUB, aalu_pkg::FUNC_SBB: begin
        state_o.acc   = sum9[7:0];
        state_o.flags = arith_flags;
      end
      aalu_pkg::FUNC_CMP: begin
        state_o.flags = arith_flags;
      end
      aalu_pkg::FUNC_ANA: begin
        state_o.acc   = a & operand_i;
        state_o.flags = aalu_pkg::szp_flags(a & operand_i, a[3] | operand_i[3], 1'b0);
      end
      aalu_pkg::FUNC_XRA: begin
        state_o.acc   = a ^ operand_i;
        state_o.flags = aalu_pkg::szp_flags(a ^ operand_i, 1'b0, 1'b0);
      end
      aalu_pkg::FUNC_ORA: begin
        state_o.acc   = a | operand_i;
        state_o.flags = aalu_pkg::szp_flags(a | operand_i, 1'b0, 1'b0);
      end
      aalu_pkg::FUNC_RLC: begin
        state_o.acc      = {a[6:0], a[7]};
        state_o.flags.cy = a[7];
      end
      aalu_pkg::FUNC_RRC: begin
        state_o.acc      = {a[0], a[7:1]};
        state_o.flags.cy = a[0];
      end
      aalu_pkg::FUNC_RAL: begin
        state_o.acc      = {a[6:0], cy};
        state_o.flags.cy = a[7];
      end
      aalu_pkg::FUNC_RAR: begin
        state_o.acc      = {cy, a[7:1]};
        state_o.flags.cy = a[0];
      end
      aalu_pkg::FUNC_CMA: begin
        state_o.acc = ~a;
      end
      aalu_pkg::FUNC_CMC: begin
        state_o.flags.cy = ~cy;
      end
      aalu_pkg::FUNC_DAA: begin
        state_o.acc   = daa_a2;
        state_o.flags = aalu_pkg::szp_flags(daa_a2, lo_adj & daa_lo5[4], cy | hi_adj);
      end
      aalu_pkg::FUNC_INR: begin
        state_o.flags = aalu_pkg::szp_flags(incdec, incdec[3:0] == 4'd0, cy);
      end
      aalu_pkg::FUNC_DCR: begin
        state_o.flags = aalu_pkg::szp_flags(incdec, operand_i[3:0] != 4'd0, cy);
      end
      aalu_pkg::FUNC_LOAD_ACC: begin
        state_o.acc = operand_i;
      end
      aalu_pkg::FUNC_LOAD_FLAG: begin
        state_o.flags.s  = operand_i[7];
        state_o.flags.z  = operand_i[6];
        state_o.flags.ac = operand_i[4];
        state_o.flags.p  = operand_i[2];
        state_o.flags.cy = operand_i[0];
      end
      default: begin
        state_o = state_i;
      end
    endcase
    // register value for inr and dcr, otherwise the new accumulator
    if (func_i inside {aalu_pkg::FUNC_INR, aalu_pkg::FUNC_DCR}) begin
      value_o = incdec;
    end else begin
      value_o = state_o.acc;
    end
  end

endmodule

// File: sv/aalu_checker.sv
// port-level checks for the accumulator alu, bound to the top level
`include "accumulator_alu_with_flags_top_macros.svh"

module aalu_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input aalu_pkg::in_item_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input aalu_pkg::out_item_t out_data_o
);

  logic in_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;

  // a stalled input keeps its valid and payload
  `AALU_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_data_i))

  // a stalled result keeps its payload
  `AALU_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, $stable(out_data_o))

  // fixed bits of the status byte
  `AALU_ASSERT_SAME(a_status_fixed, out_valid_o,
    out_data_o.status_out[1] && !out_data_o.status_out[3] && !out_data_o.status_out[5])

  // a free receiver never holds up the sender
  `AALU_ASSERT_SAME(a_no_needless_stall, !out_stall_i, !in_stall_o)

  // an accepted item passes from the input register into the result register once the result slot is free
  `AALU_ASSERT_NEXT(a_latency, in_xfer ##1 (!out_valid_o || !out_stall_i), out_valid_o)

endmodule

bind accumulator_alu_with_flags_top aalu_checker u_aalu_checker (.*);
